[sv/psb_pkg.sv]
// Shared types, codes and the colour table for the planar sprite blitter.
// No dependencies.
package psb_pkg;

    // Request command codes
    localparam logic [1:0] CMD_TRANSP = 2'd0;
    localparam logic [1:0] CMD_OPAQUE = 2'd1;
    localparam logic [1:0] CMD_TILE   = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_LINE_BLOCKS   = 1'b0;
    localparam logic CFG_DRAWABLE_ROWS = 1'b1;

    // Full word address before the store range check (row * blocks + x / 16)
    localparam int ADDR_W = 17;

    localparam int          WORD_W     = 64;
    localparam logic [7:0]  SKIP_BYTE  = 8'hCC;
    localparam logic [3:0]  SPILL_LAST = 4'd12;   // offsets above this spill
    localparam logic [2:0]  GROUP_PIX  = 3'd4;
    localparam logic [3:0]  ALL_PLANES = 4'hF;

    // 6-bit BGR palette value to 4-bit colour index
    localparam logic [3:0] COLOR_LUT [64] = '{
        4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
        4'd15, 4'd15, 4'd15, 4'd11, 4'd12, 4'd15, 4'd15, 4'd15,
        4'd8,  4'd15, 4'd15, 4'd15, 4'd9,  4'd10, 4'd6,  4'd14,
        4'd15, 4'd15, 4'd15, 4'd11, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd10, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd13, 4'd14, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd14, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15
    };

    // Clear/set masks for the target word and the spill word
    typedef struct packed {
        logic [WORD_W-1:0] clr0;
        logic [WORD_W-1:0] set0;
        logic [WORD_W-1:0] clr1;
        logic [WORD_W-1:0] set1;
        logic              spill;   // group runs into the next word
        logic              skip;    // tile group with nothing visible
    } t_psb_mask;

    // Plane bits of colour idx at pixel position pos (pixel k is bit 15-k)
    function automatic logic [WORD_W-1:0] pix_bits(input logic [3:0] idx,
                                                   input logic [3:0] pos);
        logic [15:0] oh;
        oh = 16'h8000 >> pos;
        return {idx[3] ? oh : 16'h0, idx[2] ? oh : 16'h0,
                idx[1] ? oh : 16'h0, idx[0] ? oh : 16'h0};
    endfunction

endpackage

[sv/planar_sprite_blitter_unit.sv]
// Planar bitplane sprite blitter: frame store of 64-bit, 4-plane words in one RAM.
// A read request's word passes the RAM read register, then the output register, before
// o_out_valid rises; the output register takes it only once that register is free.
// A drawing request passes through S_WR0, then S_WR1 when it writes a spill word; a
// read waits in S_RDOUT while the output register is stalled. Requests stall until S_IDLE.
// Reset: a clearing pass zeroes the store word by word, with requests stalled.
module planar_sprite_blitter_unit #(
    parameter int STORE_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [8:0]  i_row,
    input  logic [9:0]  i_pixel_x,
    input  logic [31:0] i_pixels,
    input  logic [2:0]  i_visible_count,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_word_data,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    import psb_pkg::*;

    localparam int              AW        = $clog2(STORE_WORDS);
    localparam logic [ADDR_W-1:0] STORE_LIM = ADDR_W'(STORE_WORDS);
    localparam logic [AW-1:0]   CLR_LAST  = AW'(STORE_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,    // zeroing pass after reset
        S_IDLE,     // take a request, issue its first read
        S_WR0,      // modify/write target word, read spill word
        S_WR1,      // modify/write spill word
        S_RDOUT     // hand read data to the output register
    } t_state;

    t_state r_state;

    // configuration
    logic [6:0] r_line_blocks;
    logic [9:0] r_drawable_rows;

    // request held over the read-modify-write
    logic [AW-1:0] r_addr;
    t_psb_mask     r_mask;
    logic          r_we0;
    logic          r_we1;
    logic          r_rd_ok;
    logic [AW-1:0] r_clr_addr;

    logic          r_out_valid;
    logic [63:0]   r_word_data;

    // address of the request
    logic [15:0]       row_prod;
    logic [ADDR_W-1:0] full_addr;
    logic [ADDR_W-1:0] full_addr1;
    logic              in_rng0;
    logic              in_rng1;
    logic              draw_ok;
    logic              accept;
    t_psb_mask         mask;

    assign row_prod   = i_row * r_line_blocks;
    assign full_addr  = {1'b0, row_prod} + ADDR_W'(i_pixel_x[9:4]);
    assign full_addr1 = full_addr + ADDR_W'(1);
    assign in_rng0    = full_addr < STORE_LIM;
    assign in_rng1    = full_addr1 < STORE_LIM;
    assign draw_ok    = {1'b0, i_row} < r_drawable_rows;
    assign accept     = i_in_valid && (r_state == S_IDLE);

    psb_mask u_mask (
        .i_command       (i_command),
        .i_offset        (i_pixel_x[3:0]),
        .i_pixels        (i_pixels),
        .i_visible_count (i_visible_count),
        .o_mask          (mask)
    );

    // frame store port control
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;
    logic [AW-1:0] addr1;

    assign addr1 = r_addr + AW'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = full_addr[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
            end
            S_IDLE: begin
                ram_re = accept;
            end
            S_WR0: begin
                ram_we    = r_we0;
                ram_wdata = (ram_rdata & ~r_mask.clr0) | r_mask.set0;
                // fetch the spill word while the target is written
                ram_re    = r_we1;
                ram_raddr = addr1;
            end
            S_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = addr1;
                ram_wdata = (ram_rdata & ~r_mask.clr1) | r_mask.set1;
            end
            S_RDOUT: begin
            end
            default: begin
            end
        endcase
    end

    psb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr_addr      <= '0;
            r_line_blocks   <= 7'd20;
            r_drawable_rows <= 10'd192;
            r_out_valid     <= 1'b0;
            r_we0           <= 1'b0;
            r_we1           <= 1'b0;
            r_rd_ok         <= 1'b0;
        end else begin
            // config writes are taken in any state
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LINE_BLOCKS:   r_line_blocks   <= i_cfg_data[6:0];
                    CFG_DRAWABLE_ROWS: r_drawable_rows <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // the read state refills the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_RDOUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_addr  <= full_addr[AW-1:0];
                        r_mask  <= mask;
                        r_rd_ok <= in_rng0;
                        r_we0   <= draw_ok && in_rng0 && !mask.skip;
                        r_we1   <= draw_ok && in_rng1 && mask.spill;
                        r_state <= (i_command == CMD_READ) ? S_RDOUT : S_WR0;
                    end
                end
                S_WR0: begin
                    r_state <= r_we1 ? S_WR1 : S_IDLE;
                end
                S_WR1: begin
                    r_state <= S_IDLE;
                end
                S_RDOUT: begin
                    // RAM read data holds until the output register frees up
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_word_data <= r_rd_ok ? ram_rdata : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_word_data = r_word_data;
    assign o_cfg_ready = 1'b1;

endmodule

[sv/psb_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module psb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/psb_mask.sv]
// Builds clear/set masks for one pixel group: colour lookup, placement, spill.
// Depends on psb_pkg.
module psb_mask (
    input  logic [1:0]         i_command,
    input  logic [3:0]         i_offset,
    input  logic [31:0]        i_pixels,
    input  logic [2:0]         i_visible_count,
    output psb_pkg::t_psb_mask o_mask
);
    import psb_pkg::*;

    always_comb begin
        logic [2:0]        vis;
        logic [7:0]        pbyte;
        logic [3:0]        idx;
        logic [4:0]        pos;
        logic              hi;
        logic              en;
        logic [WORD_W-1:0] bits;
        logic [WORD_W-1:0] cbits;

        vis = (i_visible_count > GROUP_PIX) ? GROUP_PIX : i_visible_count;
        o_mask = '0;
        for (int k = 0; k < 4; k++) begin
            pbyte = i_pixels[8*k +: 8];
            idx   = COLOR_LUT[pbyte[5:0]];
            pos   = {1'b0, i_offset} + 5'(k);
            // tile groups wrap inside the word, the others spill over
            hi    = (i_command != CMD_TILE) && pos[4];
            en    = (3'(k) < vis) && !(i_command == CMD_TRANSP && pbyte == SKIP_BYTE);
            bits  = pix_bits(idx, pos[3:0]);
            cbits = (i_command == CMD_TRANSP) ? pix_bits(ALL_PLANES, pos[3:0]) : '0;
            if (en) begin
                if (hi) begin
                    o_mask.set1 = o_mask.set1 | bits;
                    o_mask.clr1 = o_mask.clr1 | cbits;
                end else begin
                    o_mask.set0 = o_mask.set0 | bits;
                    o_mask.clr0 = o_mask.clr0 | cbits;
                end
            end
        end
        // aligned tile overwrites the whole word
        if (i_command == CMD_TILE && i_offset == 4'd0) begin
            o_mask.clr0 = '1;
        end
        o_mask.spill = (i_command != CMD_TILE) && (i_offset > SPILL_LAST);
        o_mask.skip  = (i_command == CMD_TILE) && (vis == 3'd0);
    end

endmodule

[verif/psb_checker.sv]
`timescale 1ns / 100ps
// Frame store checker for planar_sprite_blitter_unit: follows the request, result and
// register channels, keeps a shadow frame store and compares every word read back.
// Depends on psb_pkg for the command and register codes.
module psb_checker #(
    parameter int STORE_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_command,
    input  logic [8:0]  i_row,
    input  logic [9:0]  i_pixel_x,
    input  logic [31:0] i_pixels,
    input  logic [2:0]  i_visible_count,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_word_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_wrap_up,
    output logic [31:0] o_fail_count,
    output logic [31:0] o_pending,
    output logic [31:0] o_words_checked
);
    import psb_pkg::*;

    localparam logic [7:0] SEE_THROUGH = 8'hCC;

    // 6-bit BGR palette value to colour index
    localparam logic [3:0] PALETTE_MAP [64] = '{
        4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
        4'd15, 4'd15, 4'd15, 4'd11, 4'd12, 4'd15, 4'd15, 4'd15,
        4'd8,  4'd15, 4'd15, 4'd15, 4'd9,  4'd10, 4'd6,  4'd14,
        4'd15, 4'd15, 4'd15, 4'd11, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd10, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd13, 4'd14, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd14, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15
    };

    logic [63:0] shadow_frame [STORE_WORDS];
    logic [63:0] pending_words [$];
    logic [63:0] oldest_word;
    int          line_blocks;
    int          drawable_rows;
    int          fails = 0;
    int          checked = 0;
    bit          leftovers_done = 1'b0;

    // plane p bit of the colour lands at bit p*16 + 15 - slot
    function automatic logic [63:0] plane_bits(input logic [3:0] colour, input int slot);
        logic [63:0] m;
        m = '0;
        for (int p = 0; p < 4; p++)
            if (colour[p])
                m[p * 16 + 15 - slot] = 1'b1;
        return m;
    endfunction

    task automatic report_error(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        $display("[%0t] ERROR %s: got %h, expected %h", $time, what, got, want);
        fails++;
    endtask

    task automatic write_word(input int addr, input logic [63:0] clr, input logic [63:0] bits);
        if (addr < STORE_WORDS)
            shadow_frame[addr] = (shadow_frame[addr] & ~clr) | bits;
    endtask

    task automatic apply_request(input logic [1:0] cmd, input logic [8:0] row,
                                 input logic [9:0] px, input logic [31:0] pixels,
                                 input logic [2:0] vis);
        int          addr;
        int          slot;
        int          side;
        int          n;
        logic [7:0]  b;
        logic [63:0] clr_bits [2];
        logic [63:0] set_bits [2];

        addr = int'(row) * line_blocks + int'(px[9:4]);
        if (cmd == CMD_READ) begin
            pending_words.push_back(addr < STORE_WORDS ? shadow_frame[addr] : 64'h0);
            return;
        end
        if (int'(row) >= drawable_rows)
            return;
        n = (vis > 3'd4) ? 4 : int'(vis);
        clr_bits[0] = '0;
        clr_bits[1] = '0;
        set_bits[0] = '0;
        set_bits[1] = '0;
        for (int k = 0; k < n; k++) begin
            b = pixels[8 * k +: 8];
            if (cmd == CMD_TRANSP && b == SEE_THROUGH)
                continue;
            slot = int'(px[3:0]) + k;
            side = 0;
            if (cmd != CMD_TILE && slot > 15) begin
                side = 1;
                slot -= 16;
            end
            slot &= 15;
            set_bits[side] |= plane_bits(PALETTE_MAP[b[5:0]], slot);
            if (cmd == CMD_TRANSP)
                clr_bits[side] |= plane_bits(4'hF, slot);
        end
        if (cmd == CMD_TILE) begin
            // offset 0 replaces the whole word, any other offset ORs in
            if (n != 0)
                write_word(addr, (px[3:0] == 4'd0) ? '1 : '0, set_bits[0]);
            return;
        end
        write_word(addr, clr_bits[0], set_bits[0]);
        if (px[3:0] > 4'd12)
            write_word(addr + 1, clr_bits[1], set_bits[1]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_WORDS; i++)
                shadow_frame[i] = '0;
            pending_words.delete();
            line_blocks   = 20;
            drawable_rows = 192;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_LINE_BLOCKS)
                    line_blocks = int'(i_cfg_data[6:0]);
                else
                    drawable_rows = int'(i_cfg_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_words.size() == 0) begin
                    report_error("word_data with no read outstanding", i_word_data, 64'h0);
                end else begin
                    oldest_word = pending_words.pop_front();
                    checked++;
                    if (i_word_data !== oldest_word)
                        report_error("word_data", i_word_data, oldest_word);
                end
            end
            if (i_in_valid && !i_in_stall)
                apply_request(i_command, i_row, i_pixel_x, i_pixels, i_visible_count);
            if (i_wrap_up && !leftovers_done) begin
                leftovers_done = 1'b1;
                if (pending_words.size() != 0)
                    report_error("reads never answered", 64'(pending_words.size()), 64'h0);
            end
        end
        o_pending       <= pending_words.size();
        o_fail_count    <= fails;
        o_words_checked <= checked;
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Top of the planar_sprite_blitter_unit testbench: clock, reset, request and register
// stimulus, result stall, verdict. Depends on psb_pkg, psb_checker and the block's RTL.
module tb;
    import psb_pkg::*;

    localparam int STORE_WORDS  = 4096;
    localparam int RANDOM_ITEMS = 1450;
    localparam int PHASES       = 6;
    localparam int PER_PHASE    = RANDOM_ITEMS / PHASES;

    typedef struct packed {
        logic [1:0]  command;
        logic [8:0]  row;
        logic [9:0]  pixel_x;
        logic [31:0] pixels;
        logic [2:0]  visible_count;
    } t_blit_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [8:0]  i_row;
    logic [9:0]  i_pixel_x;
    logic [31:0] i_pixels;
    logic [2:0]  i_visible_count;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_word_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [9:0]  i_cfg_data;
    logic        wrap_up;

    logic [31:0] fail_count;
    logic [31:0] words_pending;
    logic [31:0] words_checked;

    // idle percentages of the request sender and the result receiver
    int tx_pct = 0;
    int rx_pct = 0;
    // shadow of the register settings, used to aim requests at interesting rows
    int cur_lb = 20;
    int cur_dr = 192;
    int cmd_seen [4] = '{0, 0, 0, 0};
    int settings_used = 1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    planar_sprite_blitter_unit #(
        .STORE_WORDS(STORE_WORDS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_row          (i_row),
        .i_pixel_x      (i_pixel_x),
        .i_pixels       (i_pixels),
        .i_visible_count(i_visible_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_word_data    (o_word_data),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    psb_checker #(
        .STORE_WORDS(STORE_WORDS)
    ) chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_row          (i_row),
        .i_pixel_x      (i_pixel_x),
        .i_pixels       (i_pixels),
        .i_visible_count(i_visible_count),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_word_data    (o_word_data),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_wrap_up      (wrap_up),
        .o_fail_count   (fail_count),
        .o_pending      (words_pending),
        .o_words_checked(words_checked)
    );

    // Result receiver: stalls at random, one fresh draw per cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_pct);
    end

    function automatic t_blit_req mk_req(input logic [1:0] c, input int row, input int px,
                                         input logic [31:0] pix, input int vis);
        t_blit_req r;
        r.command       = c;
        r.row           = 9'(row);
        r.pixel_x       = 10'(px);
        r.pixels        = pix;
        r.visible_count = 3'(vis);
        return r;
    endfunction

    // Random request. Most land in a small hot area near the origin so that reads
    // see what was drawn; the rest probe the drawable-rows boundary, the top of the
    // store and the full field ranges.
    function automatic t_blit_req random_request();
        t_blit_req r;
        int        zone;
        int        top_row;
        int        row;
        int        px;
        logic [7:0] b;

        r.command = ($urandom_range(99) < 30) ? CMD_READ
                                              : 2'($urandom_range(CMD_TRANSP, CMD_TILE));
        zone = $urandom_range(99);
        if (zone < 65) begin
            row = $urandom_range(0, 3);
            px  = $urandom_range(0, 63);
        end else if (zone < 75) begin
            row = cur_dr - int'($urandom_range(0, 1));
            row = (row < 0) ? 0 : (row > 511) ? 511 : row;
            px  = $urandom_range(0, 63);
        end else if (zone < 85) begin
            top_row = STORE_WORDS / cur_lb;
            top_row = (top_row > 511) ? 511 : top_row;
            row = top_row - int'($urandom_range(0, 1));
            px  = $urandom_range(0, 1) ? 1008 + int'($urandom_range(0, 15))
                                       : int'($urandom_range(0, 1023));
        end else begin
            row = $urandom_range(0, 511);
            px  = $urandom_range(0, 1023);
        end
        r.row     = 9'(row);
        r.pixel_x = 10'(px);
        if ($urandom_range(0, 1)) begin
            r.pixels = $urandom;
        end else begin
            // sprinkle see-through bytes among random palette bytes
            for (int k = 0; k < 4; k++) begin
                b = ($urandom_range(0, 3) == 0) ? 8'hCC : 8'($urandom_range(0, 255));
                r.pixels[8 * k +: 8] = b;
            end
        end
        r.visible_count = ($urandom_range(99) < 55) ? 3'd4 : 3'($urandom_range(0, 7));
        return r;
    endfunction

    // One request: optional idle gap, then hold it until the block takes it.
    // Valid is left high on return so back-to-back requests never drop it.
    task automatic send_request(input t_blit_req r);
        while ($urandom_range(99) < tx_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= r.command;
        i_row           <= r.row;
        i_pixel_x       <= r.pixel_x;
        i_pixels        <= r.pixels;
        i_visible_count <= r.visible_count;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        cmd_seen[int'(r.command)]++;
    endtask

    // Stop sending until every read is answered, then give the last drawing
    // request time to land.
    task automatic drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (words_pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Both registers in one go; valid stays high between the two writes
    task automatic program_regs(input int lb, input int dr);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LINE_BLOCKS;
        i_cfg_data  <= 10'(lb);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_index <= CFG_DRAWABLE_ROWS;
        i_cfg_data  <= 10'(dr);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_lb = lb;
        cur_dr = dr;
        settings_used++;
    endtask

    // Generous ceiling: reset clearing pass plus every request at its slowest
    initial begin
        #2_000_000;
        $display("Timed out with %0d reads outstanding", words_pending);
        $display("planar_sprite_blitter_unit: mismatch");
        $finish;
    end

    initial begin
        int lb_plan [PHASES];
        int dr_plan [PHASES];
        int waited;

        // extremes first: default, widest, narrowest, nothing drawable, a middle value
        lb_plan = '{20, 64, 1, 64, 37, 0};
        dr_plan = '{192, 512, 1, 0, 300, 0};
        lb_plan[PHASES - 1] = $urandom_range(1, 64);
        dr_plan[PHASES - 1] = $urandom_range(0, 512);

        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_command       <= CMD_TRANSP;
        i_row           <= '0;
        i_pixel_x       <= '0;
        i_pixels        <= '0;
        i_visible_count <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_LINE_BLOCKS;
        i_cfg_data      <= '0;
        wrap_up         <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                program_regs(lb_plan[phase], dr_plan[phase]);
            end
            // sender 29 / receiver 47, then swapped, then no idling at all
            case (phase / 2)
                0: begin
                    tx_pct = 29;
                    rx_pct = 47;
                end
                1: begin
                    tx_pct = 47;
                    rx_pct = 29;
                end
                default: begin
                    tx_pct = 0;
                    rx_pct = 0;
                end
            endcase

            if (phase == 0) begin
                // plain transparent draw and read back
                send_request(mk_req(CMD_TRANSP, 0, 0, 32'h03020100, 4));
                send_request(mk_req(CMD_READ, 0, 0, 32'h0, 0));
                // opaque group at offset 13 spills into the next row's first word
                send_request(mk_req(CMD_OPAQUE, 1, 317, 32'h3F3F3F3F, 4));
                send_request(mk_req(CMD_READ, 1, 304, 32'h0, 0));
                send_request(mk_req(CMD_READ, 2, 0, 32'h0, 0));
                // see-through bytes leave their pixels alone
                send_request(mk_req(CMD_TRANSP, 0, 2, 32'hCC15CC3F, 4));
                send_request(mk_req(CMD_READ, 0, 0, 32'h0, 0));
                // tile at offset 0 overwrites a filled word
                send_request(mk_req(CMD_OPAQUE, 0, 16, 32'hFFFFFFFF, 4));
                send_request(mk_req(CMD_TILE, 0, 16, 32'h2A1B0C05, 3));
                send_request(mk_req(CMD_READ, 0, 16, 32'h0, 0));
                // tile at offset 14 wraps within its word
                send_request(mk_req(CMD_TILE, 0, 46, 32'h15141312, 4));
                send_request(mk_req(CMD_READ, 0, 32, 32'h0, 0));
                // tile with nothing visible changes nothing
                send_request(mk_req(CMD_TILE, 0, 16, 32'hFFFFFFFF, 0));
                send_request(mk_req(CMD_READ, 0, 16, 32'h0, 0));
                // clip count above 4 acts as 4; clip count 0 draws nothing
                send_request(mk_req(CMD_TRANSP, 0, 48, 32'h01020304, 7));
                send_request(mk_req(CMD_OPAQUE, 0, 64, 32'h0000000F, 0));
                send_request(mk_req(CMD_READ, 0, 48, 32'h0, 0));
                send_request(mk_req(CMD_READ, 0, 64, 32'h0, 0));
                // first row past the drawable area: write dropped, read still served
                send_request(mk_req(CMD_TRANSP, 192, 0, 32'h3F3F3F3F, 4));
                send_request(mk_req(CMD_READ, 192, 0, 32'h0, 0));
                // read beyond the store returns zero
                send_request(mk_req(CMD_READ, 511, 1023, 32'h0, 0));
            end else if (phase == 1) begin
                // last word of the store; its spill word lies outside and is dropped
                send_request(mk_req(CMD_OPAQUE, 63, 1023, 32'h3F3F3F3F, 4));
                send_request(mk_req(CMD_READ, 63, 1008, 32'h0, 0));
                // drawable but outside the store
                send_request(mk_req(CMD_TRANSP, 100, 0, 32'h3F3F3F3F, 4));
                send_request(mk_req(CMD_READ, 100, 0, 32'h0, 0));
            end

            for (int n = 0; n < PER_PHASE; n++) begin
                send_request(random_request());
                if (n % 97 == 96)
                    drain();
            end
        end

        // let the last reads come back, bounded so a hung block still ends
        i_in_valid <= 1'b0;
        waited = 0;
        while (words_pending != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        wrap_up <= 1'b1;
        repeat (3) @(posedge i_clk);

        $display("Sent %0d transparent, %0d opaque, %0d tile and %0d read requests",
                 cmd_seen[CMD_TRANSP], cmd_seen[CMD_OPAQUE], cmd_seen[CMD_TILE],
                 cmd_seen[CMD_READ]);
        $display("over %0d register settings; %0d words read back were compared.",
                 settings_used, words_checked);
        if (fail_count == 0)
            $display("planar_sprite_blitter_unit: match");
        else
            $display("planar_sprite_blitter_unit: mismatch");
        $finish;
    end

endmodule
